@@ hw/rtl/rbsi_pkg.sv @@
// Package for the ray/box slab intersection unit: widths, codes, payload types.
// Used by every file under hw/rtl; depends on nothing.
package rbsi_pkg;

  localparam int unsigned CW   = 32;
  localparam int unsigned FRAC = 16;
  // dividend magnitude: |bound - origin| (CW+1 bits) scaled by 2^FRAC
  localparam int unsigned NW   = CW + 1 + FRAC;
  localparam int unsigned STEP = 4;
  localparam int unsigned DIV_STAGES = (NW + STEP - 1) / STEP;
  localparam int unsigned PAD_W = DIV_STAGES * STEP;
  // start to strobe: item reg, setup, divider stages, sort, merge
  localparam int unsigned LATENCY = DIV_STAGES + 4;

  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned IDX_W = $clog2(NUM_REGS);

  localparam logic signed [CW-1:0] T_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] T_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] FIX_ONE = CW'(1) << FRAC;
  localparam logic [NW-1:0] QPOS_MAX = {{(NW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic [NW-1:0] QNEG_MAX = QPOS_MAX + NW'(1);

  localparam logic [IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [IDX_W-1:0] REG_DIR_X    = 3'd3;
  localparam logic [IDX_W-1:0] REG_DIR_Y    = 3'd4;
  localparam logic [IDX_W-1:0] REG_DIR_Z    = 3'd5;
  localparam logic [IDX_W-1:0] REG_T_LOWER  = 3'd6;
  localparam logic [IDX_W-1:0] REG_T_UPPER  = 3'd7;

  localparam logic [1:0] OP_EARLY   = 2'd0;
  localparam logic [1:0] OP_NEAREST = 2'd1;
  localparam logic [1:0] OP_CLIPPED = 2'd2;
  localparam logic [1:0] OP_NONE    = 2'd3;

  typedef struct packed {
    logic [1:0]           opcode;
    logic signed [CW-1:0] box_min_x;
    logic signed [CW-1:0] box_min_y;
    logic signed [CW-1:0] box_min_z;
    logic signed [CW-1:0] box_max_x;
    logic signed [CW-1:0] box_max_y;
    logic signed [CW-1:0] box_max_z;
  } box_t;

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] t_near;
    logic signed [CW-1:0] t_far;
    logic signed [CW-1:0] t_chosen;
  } res_t;

  // per-item flags that ride alongside the dividers
  typedef struct packed {
    logic [1:0] opcode;
    logic [2:0] dir_zero;
    logic [2:0] in_slab;
    logic [2:0] pin_min;
    logic [2:0] pin_max;
  } side_t;

endpackage

@@ hw/rtl/ray_box_slab_intersect_unit.sv @@
// Ray versus axis-aligned box slab test, signed fixed point, fully pipelined.
// Depends on rbsi_pkg and rbsi_div_pipe.
//
// Usage:
//   Load the ray through the write port (cfg_we_i, cfg_idx_i, cfg_wdata_i):
//   origin x/y/z, direction x/y/z, lower and upper t bound. Write only while
//   no box is in flight. Indexes past the last register are dropped.
//   Boxes enter on start with box_i; busy is always low, so a box transfers
//   on every cycle that start is high. Each box yields one result on res_o,
//   marked by result_valid_o for exactly one cycle once it has passed the
//   item, setup, divider, sort and merge registers (32-bit Q16.16 data).
//   One box per cycle is sustained; the rate is set by six parallel restoring
//   dividers of DIV_STAGES stages, four quotient bits per stage.
//   The receiver cannot stall: results must be taken as they appear.
//   Reset drops everything in flight and returns the ray to origin 0,
//   direction +x, with unbounded t limits.
module ray_box_slab_intersect_unit import rbsi_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [CW-1:0]    cfg_wdata_i,
  input  logic             start,
  input  box_t             box_i,
  output logic             busy,
  output logic             result_valid_o,
  output res_t             res_o
);

  logic signed [CW-1:0] origin_q [3];
  logic signed [CW-1:0] dir_q [3];
  logic signed [CW-1:0] t_lower_q, t_upper_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q[0] <= '0;
      origin_q[1] <= '0;
      origin_q[2] <= '0;
      dir_q[0]    <= FIX_ONE;
      dir_q[1]    <= '0;
      dir_q[2]    <= '0;
      t_lower_q   <= T_MIN;
      t_upper_q   <= T_MAX;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ORIGIN_X: origin_q[0] <= cfg_wdata_i;
        REG_ORIGIN_Y: origin_q[1] <= cfg_wdata_i;
        REG_ORIGIN_Z: origin_q[2] <= cfg_wdata_i;
        REG_DIR_X:    dir_q[0]    <= cfg_wdata_i;
        REG_DIR_Y:    dir_q[1]    <= cfg_wdata_i;
        REG_DIR_Z:    dir_q[2]    <= cfg_wdata_i;
        REG_T_LOWER:  t_lower_q   <= cfg_wdata_i;
        REG_T_UPPER:  t_upper_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // valid bits for item reg, setup reg, divider stages, sort, output
  logic in_vld_q, set_vld_q, srt_vld_q, out_vld_q;
  logic [DIV_STAGES-1:0] div_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      set_vld_q <= 1'b0;
      div_vld_q <= '0;
      srt_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= start && !busy;
      set_vld_q <= in_vld_q;
      div_vld_q <= {div_vld_q[DIV_STAGES-2:0], set_vld_q};
      srt_vld_q <= div_vld_q[DIV_STAGES-1];
      out_vld_q <= srt_vld_q;
    end
  end

  box_t in_q;
  always_ff @(posedge clk_i) begin
    in_q <= box_i;
  end

  // setup: differences, magnitudes, signs, zero-direction flags
  logic signed [CW-1:0] bmin [3];
  logic signed [CW-1:0] bmax [3];
  assign bmin[0] = in_q.box_min_x;
  assign bmin[1] = in_q.box_min_y;
  assign bmin[2] = in_q.box_min_z;
  assign bmax[0] = in_q.box_max_x;
  assign bmax[1] = in_q.box_max_y;
  assign bmax[2] = in_q.box_max_z;

  logic [NW-1:0] num_d [6];
  logic [NW-1:0] num_q [6];
  logic [CW-1:0] den_d [3];
  logic [CW-1:0] den_q [3];
  logic          neg_d [6];
  logic          neg_q [6];
  side_t         side_d, side_q;
  side_t         side_pipe_q [DIV_STAGES];

  always_comb begin
    logic signed [CW:0] dlo, dhi;
    logic [CW:0]        mlo, mhi;
    side_d = '0;
    side_d.opcode = in_q.opcode;
    for (int k = 0; k < 3; k++) begin
      dlo = {bmin[k][CW-1], bmin[k]} - {origin_q[k][CW-1], origin_q[k]};
      dhi = {bmax[k][CW-1], bmax[k]} - {origin_q[k][CW-1], origin_q[k]};
      mlo = dlo[CW] ? $unsigned(-dlo) : $unsigned(dlo);
      mhi = dhi[CW] ? $unsigned(-dhi) : $unsigned(dhi);
      num_d[2*k]   = {mlo, {FRAC{1'b0}}};
      num_d[2*k+1] = {mhi, {FRAC{1'b0}}};
      den_d[k] = dir_q[k][CW-1] ? $unsigned(-dir_q[k]) : $unsigned(dir_q[k]);
      neg_d[2*k]   = dlo[CW] ^ dir_q[k][CW-1];
      neg_d[2*k+1] = dhi[CW] ^ dir_q[k][CW-1];
      side_d.dir_zero[k] = (dir_q[k] == '0);
      side_d.in_slab[k]  = (origin_q[k] >= bmin[k]) && (origin_q[k] <= bmax[k]);
      side_d.pin_min[k]  = (dlo > 0);
      side_d.pin_max[k]  = (dhi > 0);
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    den_q  <= den_d;
    neg_q  <= neg_d;
    side_q <= side_d;
    side_pipe_q[0] <= side_q;
    for (int s = 1; s < DIV_STAGES; s++) begin
      side_pipe_q[s] <= side_pipe_q[s-1];
    end
  end

  logic [NW-1:0] quo [6];
  logic          qneg [6];

  for (genvar i = 0; i < 6; i++) begin : g_div
    rbsi_div_pipe u_div (
      .clk_i (clk_i),
      .num_i (num_q[i]),
      .den_i (den_q[i / 2]),
      .neg_i (neg_q[i]),
      .quo_o (quo[i]),
      .neg_o (qneg[i])
    );
  end

  // saturate, handle zero direction, sort each slab
  side_t side_out;
  assign side_out = side_pipe_q[DIV_STAGES-1];

  logic signed [CW-1:0] lo_d [3];
  logic signed [CW-1:0] hi_d [3];
  logic signed [CW-1:0] lo_q [3];
  logic signed [CW-1:0] hi_q [3];
  logic [1:0]           srt_op_q;

  always_comb begin
    logic signed [CW-1:0] t [2];
    for (int k = 0; k < 3; k++) begin
      for (int e = 0; e < 2; e++) begin
        if (side_out.dir_zero[k]) begin
          t[e] = ((e == 0) ? side_out.pin_min[k] : side_out.pin_max[k]) ? T_MAX : T_MIN;
        end else if (qneg[2*k+e]) begin
          t[e] = (quo[2*k+e] > QNEG_MAX) ? T_MIN : -$signed(quo[2*k+e][CW-1:0]);
        end else begin
          t[e] = (quo[2*k+e] > QPOS_MAX) ? T_MAX : $signed(quo[2*k+e][CW-1:0]);
        end
      end
      if (side_out.dir_zero[k] && side_out.in_slab[k]) begin
        lo_d[k] = T_MIN;
        hi_d[k] = T_MAX;
      end else begin
        lo_d[k] = (t[0] < t[1]) ? t[0] : t[1];
        hi_d[k] = (t[0] < t[1]) ? t[1] : t[0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    srt_op_q <= side_out.opcode;
  end

  // merge slabs under the opcode
  res_t res_d, res_q;

  always_comb begin
    logic signed [CW-1:0] tn0, tf0, tn1, tf1, tn2, tf2;
    logic                 hit0;
    tn0 = lo_q[0];
    tf0 = hi_q[0];
    hit0 = 1'b1;
    tn1 = lo_q[0];
    tf1 = hi_q[0];
    for (int k = 1; k < 3; k++) begin
      if (hit0) begin
        if (tn0 > hi_q[k] || lo_q[k] > tf0) begin
          hit0 = 1'b0;
        end else begin
          if (lo_q[k] > tn0) tn0 = lo_q[k];
          if (hi_q[k] < tf0) tf0 = hi_q[k];
        end
      end
      if (lo_q[k] > tn1) tn1 = lo_q[k];
      if (hi_q[k] < tf1) tf1 = hi_q[k];
    end
    tn2 = (t_lower_q > tn1) ? t_lower_q : tn1;
    tf2 = (t_upper_q < tf1) ? t_upper_q : tf1;
    res_d = '0;
    case (srt_op_q)
      OP_EARLY: begin
        res_d.hit = hit0;
        res_d.t_near = tn0;
        res_d.t_far = tf0;
        res_d.t_chosen = tn0;
      end
      OP_NEAREST: begin
        res_d.hit = !(tf1 < 0) && !(tn1 > tf1);
        res_d.t_near = tn1;
        res_d.t_far = tf1;
        res_d.t_chosen = res_d.hit ? tn1 : tf1;
      end
      OP_CLIPPED: begin
        res_d.hit = (tn2 <= tf2);
        res_d.t_near = tn2;
        res_d.t_far = tf2;
        res_d.t_chosen = tn2;
      end
      default: res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_valid_o = out_vld_q;
  assign res_o = res_q;

endmodule

@@ hw/rtl/rbsi_div_pipe.sv @@
// Pipelined unsigned restoring divider, STEP quotient bits per stage.
// Depends on rbsi_pkg.
module rbsi_div_pipe import rbsi_pkg::*; (
  input  logic          clk_i,
  input  logic [NW-1:0] num_i,
  input  logic [CW-1:0] den_i,
  input  logic          neg_i,
  output logic [NW-1:0] quo_o,
  output logic          neg_o
);

  logic [PAD_W-1:0] num_q [DIV_STAGES];
  logic [CW:0]      rem_q [DIV_STAGES];
  logic [PAD_W-1:0] quo_q [DIV_STAGES];
  logic [CW-1:0]    den_q [DIV_STAGES];
  logic             neg_q [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [PAD_W-1:0] num_in, quo_in, num_d, quo_d;
    logic [CW:0]      rem_in, rem_d;
    logic [CW-1:0]    den_in;
    logic             neg_in;

    if (s == 0) begin : g_first
      assign num_in = PAD_W'(num_i);
      assign quo_in = '0;
      assign rem_in = '0;
      assign den_in = den_i;
      assign neg_in = neg_i;
    end else begin : g_next
      assign num_in = num_q[s-1];
      assign quo_in = quo_q[s-1];
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign neg_in = neg_q[s-1];
    end

    always_comb begin
      num_d = num_in;
      quo_d = quo_in;
      rem_d = rem_in;
      for (int j = 0; j < STEP; j++) begin
        rem_d = {rem_d[CW-1:0], num_d[PAD_W-1]};
        num_d = num_d << 1;
        if (rem_d >= {1'b0, den_in}) begin
          rem_d = rem_d - {1'b0, den_in};
          quo_d = {quo_d[PAD_W-2:0], 1'b1};
        end else begin
          quo_d = {quo_d[PAD_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      num_q[s] <= num_d;
      quo_q[s] <= quo_d;
      rem_q[s] <= rem_d;
      den_q[s] <= den_in;
      neg_q[s] <= neg_in;
    end
  end

  assign quo_o = quo_q[DIV_STAGES-1][NW-1:0];
  assign neg_o = neg_q[DIV_STAGES-1];

endmodule

@@ hw/rtl/rbsi_checker.sv @@
// Port-level checks for the slab intersection unit, bound to the top level.
// Depends on rbsi_pkg and ray_box_slab_intersect_unit.
module rbsi_checker import rbsi_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input box_t box_i,
  input logic busy,
  input logic result_valid_o,
  input res_t res_o
);

  // a result only ever follows a transfer by the fixed latency
  a_result_has_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, LATENCY))
    else $error("result without matching transfer");

  a_unused_op_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && $past(box_i.opcode == OP_NONE, LATENCY) |-> res_o == '0)
    else $error("unassigned opcode gave nonzero result");

  a_clip_hit_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && $past(box_i.opcode == OP_CLIPPED, LATENCY) |->
      res_o.hit == (res_o.t_near <= res_o.t_far))
    else $error("clipped hit disagrees with interval");

  a_nearest_chosen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && $past(box_i.opcode == OP_NEAREST, LATENCY) |->
      res_o.t_chosen == (res_o.hit ? res_o.t_near : res_o.t_far))
    else $error("nearest-hit chosen t wrong");

endmodule

bind ray_box_slab_intersect_unit rbsi_checker u_rbsi_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .box_i          (box_i),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .res_o          (res_o)
);
